@@ src/qclt_pkg.sv @@
// package for the quoted command line tokenizer
// shared types, character codes, scan mode codes and helper functions
`default_nettype none

package qclt_pkg;

  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

  localparam logic [1:0] MODE_BETWEEN       = 2'd0;
  localparam logic [1:0] MODE_WORD          = 2'd1;
  localparam logic [1:0] MODE_QUOTED        = 2'd2;
  localparam logic [1:0] MODE_QUOTE_PENDING = 2'd3;

  localparam logic [0:0] CFG_ESCAPE_MODE      = 1'd0;
  localparam logic [0:0] CFG_CLOSE_UNBALANCED = 1'd1;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_EOL  = 1'b1;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       token_end;
    logic       line_end;
    logic       error;
  } result_t;

  typedef struct packed {
    logic [1:0] scan_mode;
    logic       token_seen;
  } scan_state_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } push_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic is_special(input logic [7:0] c);
    return (c == CH_BSLASH) || (c == CH_QMARK) || (c == CH_STAR) ||
           (c == CH_LBRACK) || (c == CH_RBRACK);
  endfunction

  function automatic result_t mk_res(input logic [7:0] b, input logic has,
                                     input logic tend, input logic lend,
                                     input logic err);
    result_t r;
    r.out_byte  = has ? b : 8'd0;
    r.has_byte  = has;
    r.token_end = tend;
    r.line_end  = lend;
    r.error     = err;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/qclt_if.sv @@
// item channel interfaces for the quoted command line tokenizer
// depends on nothing; input channel carries op and in_byte, output channel one result
`default_nettype none

interface qclt_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] in_byte;

  modport source (output valid, output op, output in_byte, input ready);
  modport sink (input valid, input op, input in_byte, output ready);
endinterface

interface qclt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       token_end;
  logic       line_end;
  logic       error;

  modport source (output valid, output out_byte, output has_byte, output token_end,
                  output line_end, output error, input ready);
  modport sink (input valid, input out_byte, input has_byte, input token_end,
                input line_end, input error, output ready);
endinterface

`default_nettype wire

@@ src/quoted_command_line_tokenizer_core.sv @@
// Tokenizer core: takes one line byte or end-of-line item per cycle while the result
// queue has room and returns token characters, token ends and line ends. Each accepted
// item updates the scan state in the same cycle and leaves zero, one or two results in
// a four-entry result queue; results are registered in the queue and leave at one per
// cycle while the output is ready. Input ready stays high while the queue has two free
// entries, so items flow at one per cycle; an escaped quoted character yields two
// results and the output port then sets the pace at one result per cycle. Depends on
// qclt_pkg, qclt_if, qclt_step and qclt_res_fifo.
`default_nettype none

module quoted_command_line_tokenizer_core (
  input  var logic       clk_i,
  input  var logic       rst_ni,
  input  var logic       cfg_we_i,
  input  var logic [0:0] cfg_idx_i,
  input  var logic [0:0] cfg_wdata_i,
  qclt_in_if.sink        in_if,
  qclt_out_if.source     out_if
);
  import qclt_pkg::*;

  logic        esc_q, close_q;
  scan_state_t st_q, st_d;
  push_t       step_push, push;
  result_t     head;
  logic        in_acc, room, head_valid;

  assign in_if.ready = room;
  assign in_acc      = in_if.valid && room;

  qclt_step u_step (
    .st_i    (st_q),
    .esc_i   (esc_q),
    .close_i (close_q),
    .op_i    (in_if.op),
    .c_i     (in_if.in_byte),
    .st_o    (st_d),
    .push_o  (step_push)
  );

  always_comb begin
    push = step_push;
    if (!in_acc) begin
      push.count = 2'd0;
    end
  end

  qclt_res_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_if.ready),
    .head_o  (head),
    .valid_o (head_valid),
    .room_o  (room)
  );

  assign out_if.valid     = head_valid;
  assign out_if.out_byte  = head.out_byte;
  assign out_if.has_byte  = head.has_byte;
  assign out_if.token_end = head.token_end;
  assign out_if.line_end  = head.line_end;
  assign out_if.error     = head.error;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q   <= 1'b1;
      close_q <= 1'b0;
      st_q    <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_ESCAPE_MODE) begin
        esc_q <= cfg_wdata_i[0];
      end
      if (cfg_we_i && cfg_idx_i == CFG_CLOSE_UNBALANCED) begin
        close_q <= cfg_wdata_i[0];
      end
      if (in_acc) begin
        st_q <= st_d;
      end
    end
  end

`ifndef SYNTH
  a_eol_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_if.op == OP_EOL) |=> (st_q == '0))
    else $error("scan state not cleared after end of line");
  a_two_needs_esc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.count == 2'd2) |-> (esc_q && st_q.scan_mode == MODE_QUOTED))
    else $error("two results outside escaped quote");
  a_err_is_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_valid && head.error) |-> (head.line_end && !head.token_end && !head.has_byte))
    else $error("error result malformed");
  a_eol_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_if.op == OP_EOL) |-> (push.count == 2'd1 && push.res0.line_end))
    else $error("end of line without line end result");
`endif

endmodule

`default_nettype wire

@@ src/qclt_step.sv @@
// scan step: next scan state and up to two results for one item
// depends on qclt_pkg
`default_nettype none

module qclt_step (
  input  var qclt_pkg::scan_state_t st_i,
  input  var logic                  esc_i,
  input  var logic                  close_i,
  input  var logic                  op_i,
  input  var logic [7:0]            c_i,
  output var qclt_pkg::scan_state_t st_o,
  output var qclt_pkg::push_t       push_o
);
  import qclt_pkg::*;

  logic unq;

  always_comb begin
    st_o        = st_i;
    push_o      = '0;
    unq         = 1'b0;
    if (op_i == OP_EOL) begin
      push_o.count = 2'd1;
      case (st_i.scan_mode)
        MODE_BETWEEN: begin
          push_o.res0 = mk_res(8'd0, 1'b0, !st_i.token_seen, 1'b1, 1'b0);
        end
        MODE_QUOTED: begin
          push_o.res0 = mk_res(8'd0, 1'b0, close_i, 1'b1, !close_i);
        end
        default: begin
          push_o.res0 = mk_res(8'd0, 1'b0, 1'b1, 1'b1, 1'b0);
        end
      endcase
      st_o = '0;
    end else begin
      case (st_i.scan_mode)
        MODE_QUOTED: begin
          if (c_i == CH_QUOTE) begin
            st_o.scan_mode = MODE_QUOTE_PENDING;
          end else if (esc_i && is_special(c_i)) begin
            push_o.count = 2'd2;
            push_o.res0  = mk_res(CH_BSLASH, 1'b1, 1'b0, 1'b0, 1'b0);
            push_o.res1  = mk_res(c_i, 1'b1, 1'b0, 1'b0, 1'b0);
          end else begin
            push_o.count = 2'd1;
            push_o.res0  = mk_res(c_i, 1'b1, 1'b0, 1'b0, 1'b0);
          end
        end
        MODE_QUOTE_PENDING: begin
          if (c_i == CH_QUOTE) begin
            st_o.scan_mode = MODE_QUOTED;
            push_o.count   = 2'd1;
            push_o.res0    = mk_res(CH_QUOTE, 1'b1, 1'b0, 1'b0, 1'b0);
          end else begin
            unq = 1'b1;
          end
        end
        default: begin
          unq = 1'b1;
        end
      endcase
      if (unq) begin
        // closing quote counts as being inside a word
        if (is_blank(c_i)) begin
          st_o.scan_mode = MODE_BETWEEN;
          if (st_i.scan_mode == MODE_WORD || st_i.scan_mode == MODE_QUOTE_PENDING) begin
            push_o.count = 2'd1;
            push_o.res0  = mk_res(8'd0, 1'b0, 1'b1, 1'b0, 1'b0);
          end
        end else if (c_i == CH_QUOTE) begin
          st_o.token_seen = 1'b1;
          st_o.scan_mode  = MODE_QUOTED;
        end else begin
          st_o.token_seen = 1'b1;
          st_o.scan_mode  = MODE_WORD;
          push_o.count    = 2'd1;
          push_o.res0     = mk_res(c_i, 1'b1, 1'b0, 1'b0, 1'b0);
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ src/qclt_res_fifo.sv @@
// result queue: takes up to two results a cycle, gives one a cycle while pop_i is high
// depends on qclt_pkg
`default_nettype none

module qclt_res_fifo (
  input  var logic              clk_i,
  input  var logic              rst_ni,
  input  var qclt_pkg::push_t   push_i,
  input  var logic              pop_i,
  output var qclt_pkg::result_t head_o,
  output var logic              valid_o,
  output var logic              room_o
);
  import qclt_pkg::*;

  result_t                mem_q [RES_DEPTH];
  logic [RES_PTR_W-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [RES_CNT_W-1:0]   count_q, count_d;
  logic                   pop;

  assign valid_o = (count_q != '0);
  assign room_o  = (count_q <= RES_CNT_W'(RES_DEPTH - 2));
  assign head_o  = mem_q[rptr_q];
  assign pop     = pop_i && valid_o;

  always_comb begin
    wptr_d  = wptr_q + RES_PTR_W'(push_i.count);
    rptr_d  = rptr_q + RES_PTR_W'(pop);
    count_d = count_q + RES_CNT_W'(push_i.count) - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wptr_q] <= push_i.res0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wptr_q + RES_PTR_W'(1)] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= RES_CNT_W'(RES_DEPTH))
    else $error("result queue overflow");
  a_push_with_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |-> room_o)
    else $error("push without room");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    RES_PTR_W'(count_q) == RES_PTR_W'(wptr_q - rptr_q))
    else $error("pointers disagree with count");
`endif

endmodule

`default_nettype wire

@@ test/qclt_token_checker.sv @@
// checker for the quoted command line tokenizer: watches config writes and both item channels,
// predicts the token results of each accepted item and compares them in order
// depends on qclt_pkg and qclt_if
module qclt_token_checker
  import qclt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [0:0] cfg_wdata_i,
  qclt_in_if         in_if,
  qclt_out_if        out_if,
  output int         fail_count_o,
  output int         pending_o,
  output int         results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic       escape_on;
  logic       close_quietly;
  logic [1:0] lex_mode;
  logic       word_started;
  result_t    token_q[$];
  result_t    want;

  function automatic logic blank_char(input logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB};
  endfunction

  function automatic logic pattern_char(input logic [7:0] c);
    return c inside {CH_BSLASH, CH_QMARK, CH_STAR, CH_LBRACK, CH_RBRACK};
  endfunction

  function automatic void queue_token(input logic [7:0] b, input logic has, input logic tend,
                                      input logic lend, input logic err);
    result_t r;
    r.out_byte  = has ? b : 8'd0;
    r.has_byte  = has;
    r.token_end = tend;
    r.line_end  = lend;
    r.error     = err;
    token_q.push_back(r);
  endfunction

  function automatic void predict_item(input logic op, input logic [7:0] c);
    if (op == OP_EOL) begin
      case (lex_mode)
        MODE_BETWEEN: queue_token(8'd0, 1'b0, !word_started, 1'b1, 1'b0);
        MODE_QUOTED: begin
          if (close_quietly) queue_token(8'd0, 1'b0, 1'b1, 1'b1, 1'b0);
          else queue_token(8'd0, 1'b0, 1'b0, 1'b1, 1'b1);
        end
        default: queue_token(8'd0, 1'b0, 1'b1, 1'b1, 1'b0);
      endcase
      lex_mode     = MODE_BETWEEN;
      word_started = 1'b0;
      return;
    end
    if (lex_mode == MODE_QUOTED) begin
      if (c == CH_QUOTE) begin
        lex_mode = MODE_QUOTE_PENDING;
      end else begin
        if (escape_on && pattern_char(c)) queue_token(CH_BSLASH, 1'b1, 1'b0, 1'b0, 1'b0);
        queue_token(c, 1'b1, 1'b0, 1'b0, 1'b0);
      end
    end else if (lex_mode == MODE_QUOTE_PENDING && c == CH_QUOTE) begin
      lex_mode = MODE_QUOTED;
      queue_token(CH_QUOTE, 1'b1, 1'b0, 1'b0, 1'b0);
    end else if (blank_char(c)) begin
      // a closed quote counts as part of a word
      if (lex_mode != MODE_BETWEEN) queue_token(8'd0, 1'b0, 1'b1, 1'b0, 1'b0);
      lex_mode = MODE_BETWEEN;
    end else begin
      word_started = 1'b1;
      if (c == CH_QUOTE) begin
        lex_mode = MODE_QUOTED;
      end else begin
        lex_mode = MODE_WORD;
        queue_token(c, 1'b1, 1'b0, 1'b0, 1'b0);
      end
    end
  endfunction

  function automatic void check_field(input string name, input int exp_val, input int got_val);
    if (exp_val != got_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, got_val);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      escape_on     = 1'b1;
      close_quietly = 1'b0;
      lex_mode      = MODE_BETWEEN;
      word_started  = 1'b0;
      token_q.delete();
      fail_count_o  = 0;
      pending_o     = 0;
      results_o     = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ESCAPE_MODE:      escape_on = cfg_wdata_i[0];
          CFG_CLOSE_UNBALANCED: close_quietly = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) begin
        results_o++;
        if (token_q.size() == 0) begin
          $error("result item with nothing expected: byte %0h", out_if.out_byte);
          fail_count_o++;
        end else begin
          want = token_q.pop_front();
          check_field("out_byte", want.out_byte, out_if.out_byte);
          check_field("has_byte", want.has_byte, out_if.has_byte);
          check_field("token_end", want.token_end, out_if.token_end);
          check_field("line_end", want.line_end, out_if.line_end);
          check_field("error", want.error, out_if.error);
        end
      end
      if (in_if.valid && in_if.ready) predict_item(in_if.op, in_if.in_byte);
      pending_o = token_q.size();
    end
  end

endmodule

@@ test/tb_quoted_command_line_tokenizer_core.sv @@
// testbench top for the quoted command line tokenizer core: directed lines, then random
// command lines under several register settings with bursty input and a stalling output
// depends on qclt_pkg, qclt_if, the core and qclt_token_checker
module tb_quoted_command_line_tokenizer_core;
  import qclt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 205;

  typedef struct packed {
    logic       op;
    logic [7:0] ch;
  } line_item_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we;
  logic [0:0] cfg_idx;
  logic [0:0] cfg_wdata;
  int         fail_count;
  int         pending;
  int         results;
  int         items_sent;
  int         lines_sent;
  int         settings_used;
  int         burst_left;
  int         idle_cycles;
  line_item_t line_q[$];
  logic [7:0] specials[5] = '{CH_BSLASH, CH_QMARK, CH_STAR, CH_LBRACK, CH_RBRACK};

  qclt_in_if  in_ch ();
  qclt_out_if out_ch ();

  quoted_command_line_tokenizer_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  qclt_token_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .results_o   (results)
  );

  always begin
    #1ns clk_i = 1'b1;
    #1ns clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: changing stall patterns, plus long hold-offs while items keep coming
  initial begin
    int mode;
    int left;
    int hold_left;
    int hold_at;
    out_ch.ready = 1'b0;
    mode = 0;
    left = 0;
    hold_left = 0;
    hold_at = 600;
    forever begin
      @(negedge clk_i);
      if (hold_at <= 1200 && items_sent >= hold_at) begin
        hold_at += 600;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(5, 60);
        end
        left--;
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= ($urandom_range(0, 3) != 0);
          default: out_ch.ready <= (left % 5 > 1);
        endcase
      end
    end
  end

  task automatic send_item(input logic op, input logic [7:0] ch);
    if (burst_left == 0) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 30);
    end
    @(negedge clk_i);
    in_ch.valid   <= 1'b1;
    in_ch.op      <= op;
    in_ch.in_byte <= ch;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_line();
    line_item_t it;
    while (line_q.size() > 0) begin
      it = line_q.pop_front();
      send_item(it.op, it.ch);
    end
    lines_sent++;
  endtask

  function automatic void add_byte(input logic [7:0] c);
    line_q.push_back('{OP_BYTE, c});
  endfunction

  function automatic void add_eol();
    line_q.push_back('{OP_EOL, 8'd0});
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void add_blanks();
    repeat ($urandom_range(1, 3)) add_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0: begin
        do c = 8'($urandom_range(0, 255));
        while (c inside {CH_SPACE, CH_TAB, CH_QUOTE});
      end
      1: c = specials[$urandom_range(0, 4)];
      default: c = 8'(8'h61 + $urandom_range(0, 25));
    endcase
    return c;
  endfunction

  function automatic void add_quoted_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0: begin
        do c = 8'($urandom_range(0, 255));
        while (c == CH_QUOTE);
        add_byte(c);
      end
      1, 2: add_byte(specials[$urandom_range(0, 4)]);
      3: add_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      4: begin
        add_byte(CH_QUOTE);
        add_byte(CH_QUOTE);
      end
      default: add_byte(8'(8'h61 + $urandom_range(0, 25)));
    endcase
  endfunction

  function automatic void build_random_line();
    int ntok;
    int nparts;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(0, 12)) add_byte(8'($urandom_range(0, 255)));
      add_eol();
      return;
    end
    if ($urandom_range(0, 3) == 0) add_blanks();
    ntok = $urandom_range(0, 4);
    for (int t = 0; t < ntok; t++) begin
      if (t > 0) add_blanks();
      nparts = $urandom_range(1, 3);
      for (int p = 0; p < nparts; p++) begin
        if ($urandom_range(0, 2) == 0) begin
          repeat ($urandom_range(1, 4)) add_byte(plain_char());
        end else begin
          add_byte(CH_QUOTE);
          repeat ($urandom_range(0, 5)) add_quoted_char();
          // now and then the last quote of the line stays open
          if (!(t == ntok - 1 && p == nparts - 1 && $urandom_range(0, 7) == 0))
            add_byte(CH_QUOTE);
        end
      end
    end
    if ($urandom_range(0, 3) == 0) add_blanks();
    add_eol();
  endfunction

  task automatic drain();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_regs(input logic esc, input logic close_q);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_ESCAPE_MODE;
    cfg_wdata <= esc;
    @(negedge clk_i);
    cfg_idx   <= CFG_CLOSE_UNBALANCED;
    cfg_wdata <= close_q;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [1:0] regs_q[$];
    logic [1:0] setting;
    in_ch.valid   = 1'b0;
    in_ch.op      = OP_BYTE;
    in_ch.in_byte = 8'd0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_ESCAPE_MODE;
    cfg_wdata     = 1'b0;
    items_sent    = 0;
    lines_sent    = 0;
    settings_used = 1;
    burst_left    = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // blank line, blanks and byte extremes, quoting with escapes and an open quote, empty quotes
    add_eol();
    send_line();
    add_text(" \t");
    add_byte(8'h00);
    add_byte(CH_TAB);
    add_byte(8'hFF);
    add_byte(CH_SPACE);
    add_eol();
    send_line();
    add_text("'a''\\?*[]'b'");
    add_eol();
    send_line();
    add_text("''");
    add_eol();
    send_line();

    regs_q = '{2'b00, 2'b11, 2'b01, 2'b10};
    repeat (4) regs_q.push_back(2'($urandom_range(0, 3)));
    foreach (regs_q[i]) begin
      setting = regs_q[i];
      drain();
      write_regs(setting[1], setting[0]);
      repeat (PHASE_ITEMS) begin
        build_random_line();
        send_line();
        if (items_sent >= 24 + PHASE_ITEMS * (i + 1)) break;
      end
    end
    drain();

    $display("covered %0d lines, %0d input items and %0d result items over %0d register settings",
             lines_sent, items_sent, results, settings_used);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/qclt_pkg.sv
src/qclt_if.sv
src/qclt_step.sv
src/qclt_res_fifo.sv
src/quoted_command_line_tokenizer_core.sv
test/qclt_token_checker.sv
test/tb_quoted_command_line_tokenizer_core.sv
